// File: hw/rtl/sgm_pkg.sv
// Shared constants and types for the stereo gain and dBFS level meter.
// No dependencies.
package sgm_pkg;
  localparam int MaxFramesDefault  = 4096;
  localparam int SampleBitsDefault = 16;
  localparam int VolBits           = 17;
  localparam logic [16:0] Unity    = 17'd65536;
  localparam logic signed [15:0] DbFloor = -16'sd25600;
  localparam logic [17:0] TenLog2  = 18'd197283;

  // controller to datapath
  typedef struct packed {
    logic take;      // accept frame: gain, count
    logic acc;       // add squares of the held output samples
    logic lg_start;  // start log of sum (0) or count (1)
    logic lg_sel_n;
    logic lg_step;
    logic lg_load;   // capture log result
    logic fin;       // form level, update held level of chan
    logic fin_floor;
    logic chan;      // 0 left, 1 right
    logic emit;      // load output register
  } sgm_cmd_t;

  typedef struct packed {
    logic closes;
    logic enable;
    logic lg_done;
  } sgm_sts_t;
endpackage

// File: hw/rtl/sgm_datapath.sv
// Datapath: gain multiply, square accumulators, iterative log2, dB scaling.
// Depends on sgm_pkg.
module sgm_datapath #(
  parameter int MAX_FRAMES  = sgm_pkg::MaxFramesDefault,
  parameter int SAMPLE_BITS = sgm_pkg::SampleBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [sgm_pkg::VolBits-1:0] cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_l,
  input  logic signed [SAMPLE_BITS-1:0] in_r,
  input  logic in_last,
  input  logic in_en,
  input  sgm_pkg::sgm_cmd_t cmd,
  output sgm_pkg::sgm_sts_t sts,
  output logic signed [SAMPLE_BITS-1:0] o_l,
  output logic signed [SAMPLE_BITS-1:0] o_r,
  output logic signed [15:0] o_lvl_l,
  output logic signed [15:0] o_lvl_r,
  output logic o_upd
);
  import sgm_pkg::*;
  localparam int CB = $clog2(MAX_FRAMES + 1);
  localparam int SB = 2 * SAMPLE_BITS;
  localparam int AB = SB + CB;
  localparam int EB = $clog2(AB);
  localparam logic [CB-1:0] MaxF = CB'(MAX_FRAMES);

  logic [16:0] vol;
  logic [16:0] vol_next;
  logic [31:0] gain;
  logic signed [SAMPLE_BITS-1:0] gl, gr;
  logic [AB-1:0] sum_l, sum_r;
  logic [CB-1:0] cnt;
  logic lst, en_q;
  logic signed [15:0] held_l, held_r;

  // square the volume as it is written, so the gain is ready for the next frame
  assign vol_next = (cfg_data > Unity) ? Unity : cfg_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      vol <= Unity;
      gain <= '0;
    end else if (cfg_we) begin
      vol <= vol_next;
      gain <= {16'd0, vol_next[15:0]} * {16'd0, vol_next[15:0]};
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] do_gain(
    input logic signed [SAMPLE_BITS-1:0] s, input logic [31:0] g, input logic unity);
    logic signed [SAMPLE_BITS+33:0] p;
    begin
      p = s * $signed({1'b0, g}) + (SAMPLE_BITS+34)'(64'sd1 <<< 31);
      do_gain = unity ? s : p[SAMPLE_BITS+31:32];
    end
  endfunction

  logic [CB-1:0] cnt_inc;
  assign cnt_inc = cnt + 1'b1;
  assign gl = do_gain(in_l, gain, vol[16]);
  assign gr = do_gain(in_r, gain, vol[16]);

  logic signed [SB-1:0] sq_l, sq_r;
  assign sq_l = o_l * o_l;
  assign sq_r = o_r * o_r;

  // log2 unit: normalise then 16 squaring steps
  logic [EB-1:0] lg_e;
  logic [30:0] lg_m;
  logic [15:0] lg_f;
  logic [4:0] lg_k;
  logic [63:0] sq;
  logic [EB-1:0] msb;
  logic [AB-1:0] lsrc;
  logic signed [EB+17:0] lg_a, lg_b;
  logic [30:0] norm;

  always_comb begin
    lsrc = cmd.lg_sel_n ? AB'(cnt) : (cmd.chan ? sum_r : sum_l);
    msb = '0;
    for (int i = 0; i < AB; i++) if (lsrc[i]) msb = EB'(i);
    if (msb >= EB'(30)) norm = 31'(lsrc >> (msb - EB'(30)));
    else norm = 31'(lsrc << (EB'(30) - msb));
  end
  assign sq = 64'(lg_m) * 64'(lg_m);

  always_ff @(posedge clk) begin
    if (cmd.lg_start) begin
      lg_e <= msb; lg_m <= norm; lg_f <= '0; lg_k <= '0;
    end else if (cmd.lg_step) begin
      lg_k <= lg_k + 5'd1;
      if (sq[61]) begin
        lg_m <= sq[61:31]; lg_f <= {lg_f[14:0], 1'b1};
      end else begin
        lg_m <= sq[60:30]; lg_f <= {lg_f[14:0], 1'b0};
      end
    end
    if (cmd.lg_load) begin
      lg_b <= lg_a;
      lg_a <= $signed({2'b0, lg_e, lg_f});
    end
  end
  assign sts.lg_done = (lg_k == 5'd16);

  // level: (La - Ln - off) * 197283, rounded, clamped
  logic zero_sum;
  logic signed [EB+19:0] d;
  logic signed [EB+39:0] prod;
  logic signed [EB+15:0] r;
  logic signed [15:0] lvl;
  always_comb begin
    d = (EB+20)'(lg_b) - (EB+20)'(lg_a) - (EB+20)'(2*(SAMPLE_BITS-1)*65536);
    prod = d * $signed({1'b0, TenLog2}) + (EB+40)'(1 << 23);
    r = prod[EB+39:24];
    if (zero_sum || r < (EB+16)'(DbFloor)) lvl = DbFloor;
    else if (r > 0) lvl = '0;
    else lvl = 16'(r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_l <= '0; sum_r <= '0; cnt <= '0;
      held_l <= DbFloor; held_r <= DbFloor;
      o_upd <= 1'b0;
    end else begin
      if (cmd.take) begin
        o_l <= gl; o_r <= gr;
        cnt <= cnt_inc;
        lst <= in_last || (cnt_inc >= MaxF);
        en_q <= in_en;
      end
      if (cmd.acc) begin
        sum_l <= sum_l + AB'($unsigned(sq_l));
        sum_r <= sum_r + AB'($unsigned(sq_r));
      end
      if (cmd.lg_start && !cmd.lg_sel_n) zero_sum <= (lsrc == '0);
      if (cmd.fin) begin
        if (cmd.chan) held_r <= cmd.fin_floor ? DbFloor : lvl;
        else held_l <= cmd.fin_floor ? DbFloor : lvl;
      end
      if (cmd.emit) begin
        o_lvl_l <= cmd.fin && !cmd.chan ? (cmd.fin_floor ? DbFloor : lvl) : held_l;
        o_lvl_r <= cmd.fin && cmd.chan ? (cmd.fin_floor ? DbFloor : lvl) : held_r;
        o_upd <= lst;
        if (lst) begin
          sum_l <= '0; sum_r <= '0; cnt <= '0;
        end
      end
    end
  end
  assign sts.closes = lst;
  assign sts.enable = en_q;
endmodule

// File: hw/rtl/sgm_ctrl.sv
// Controller: sequences accept, per-channel log2 runs and result hand-off.
// Depends on sgm_pkg.
module sgm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sgm_pkg::sgm_sts_t sts,
  output sgm_pkg::sgm_cmd_t cmd
);
  import sgm_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_LS, S_LSR, S_LSL, S_LN, S_LNR, S_LNL, S_FIN, S_OUT
  } state_t;
  state_t state;
  logic ch;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.chan = ch;
    unique case (state)
      S_IDLE: cmd.take = in_valid;
      S_LS:   begin cmd.lg_start = 1'b1; end
      S_LSR:  cmd.lg_step = !sts.lg_done;
      S_LSL:  cmd.lg_load = 1'b1;
      S_LN:   begin cmd.lg_start = 1'b1; cmd.lg_sel_n = 1'b1; end
      S_LNR:  cmd.lg_step = !sts.lg_done;
      S_LNL:  cmd.lg_load = 1'b1;
      S_FIN:  begin
        cmd.fin = 1'b1; cmd.fin_floor = !sts.enable;
        cmd.emit = ch;
      end
      S_CHK:  begin
        cmd.acc = 1'b1;
        cmd.emit = !sts.closes;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ch <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHK;
        S_CHK: begin
          ch <= 1'b0;
          state <= !sts.closes ? S_OUT : (sts.enable ? S_LS : S_FIN);
        end
        S_LS:  state <= S_LSR;
        S_LSR: if (sts.lg_done) state <= S_LSL;
        S_LSL: state <= S_LN;
        S_LN:  state <= S_LNR;
        S_LNR: if (sts.lg_done) state <= S_LNL;
        S_LNL: state <= S_FIN;
        S_FIN: begin
          if (ch) state <= S_OUT;
          else begin
            ch <= 1'b1;
            state <= sts.enable ? S_LS : S_FIN;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/stereo_gain_rms_dbfs_meter.sv
// Stereo master gain with block RMS level meter in dBFS (Q8.8).
// Top level; depends on sgm_pkg, sgm_ctrl, sgm_datapath.
//
// Input channel: one stereo frame per transfer (in_valid/in_ready) with
// last_frame and meter_enable. Output channel (out_valid/out_ready): gained
// samples plus held block levels and level_updated.
// master_volume_we/master_volume write the Q1.16 volume; values above unity
// clamp to unity. Write only while idle.
// An ordinary frame is accepted, has its result loaded in S_CHK and is
// offered in S_OUT. A block-closing frame with metering on runs the shared
// log2 unit four times (sum and count per channel, 16 squaring steps each);
// with metering off it floors both levels instead. One frame is in work at a
// time; the next can be taken in the cycle after its result transfers.
// Reset clears the sums and count, sets volume to unity and both held levels
// to -100 dB. A stalled receiver holds the result and blocks input.
module stereo_gain_rms_dbfs_meter #(
  parameter int MAX_FRAMES  = sgm_pkg::MaxFramesDefault,
  parameter int SAMPLE_BITS = sgm_pkg::SampleBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic master_volume_we,
  input  logic [sgm_pkg::VolBits-1:0] master_volume,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic last_frame,
  input  logic meter_enable,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic signed [15:0] level_left_db,
  output logic signed [15:0] level_right_db,
  output logic level_updated
);
  import sgm_pkg::*;
  sgm_cmd_t cmd;
  sgm_sts_t sts;

  sgm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  sgm_datapath #(.MAX_FRAMES(MAX_FRAMES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cfg_we(master_volume_we), .cfg_data(master_volume),
    .in_l(left_sample), .in_r(right_sample), .in_last(last_frame),
    .in_en(meter_enable), .cmd, .sts,
    .o_l(out_left), .o_r(out_right), .o_lvl_l(level_left_db),
    .o_lvl_r(level_right_db), .o_upd(level_updated)
  );
endmodule
